// File: rtl/core/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types and constants of the smooth pan profile generator.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_WIDTH = 32;
  localparam int unsigned DT_WIDTH  = 16;
  localparam int unsigned DUR_WIDTH = 24;
  localparam int unsigned EL_WIDTH  = 25;

  // 4/pi in Q1.30
  localparam logic [30:0] FOUR_OVER_PI_Q30 = 31'd1367130551;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_SET  = 2'd2
  } op_e;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

endpackage

// File: rtl/core/spp_if.sv
// ----------------------------------------------------------------------------
// spp_if
// Valid/ready channels of the smooth pan profile generator.
// ----------------------------------------------------------------------------
interface spp_in_if;
  import spp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [DT_WIDTH-1:0]  time_step;
  pos_t                 target_x;
  pos_t                 target_y;
  logic [DUR_WIDTH-1:0] duration;

  modport source (output valid, output op, output time_step, output target_x,
                  output target_y, output duration, input ready);
  modport sink   (input valid, input op, input time_step, input target_x,
                  input target_y, input duration, output ready);
endinterface

interface spp_out_if;
  import spp_pkg::*;

  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  logic in_motion;

  modport source (output valid, output pos_x, output pos_y, output in_motion,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input in_motion,
                  output ready);
endinterface

// File: rtl/core/smooth_pan_profile_2d.sv
// ----------------------------------------------------------------------------
// smooth_pan_profile_2d
// 2D point-to-point move generator with a semicircular speed profile.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | accepted when
//  in_i    | in  | op, time_step, target_x, target_y, duration | valid & ready
//  out_o   | out | pos_x, pos_y, in_motion                     | valid & ready
//
//  Set position, jump, idle tick and final tick take no engine work. A moving
//  tick and a move command run through the bit-serial multiplier, the restoring
//  divider (one quotient bit a cycle) and the square root unit (one result
//  bit a cycle), all shared.
//  Reset clears the position, goal, motion state and the output valid flag.
//  A stalled output holds the result; the next item is taken meanwhile and
//  waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module smooth_pan_profile_2d (
  input  logic      clk_i,
  input  logic      rst_ni,
  spp_in_if.sink    in_i,
  spp_out_if.source out_o
);
  import spp_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_TT   = 17'h00002,
    S_NN   = 17'h00004,
    S_TSQ  = 17'h00008,
    S_TDIV = 17'h00010,
    S_VDT  = 17'h00020,
    S_PW   = 17'h00040,
    S_SX   = 17'h00080,
    S_SY   = 17'h00100,
    S_AXX  = 17'h00200,
    S_AYY  = 17'h00400,
    S_MSQ  = 17'h00800,
    S_DX   = 17'h01000,
    S_DY   = 17'h02000,
    S_DK   = 17'h04000,
    S_QDIV = 17'h08000,
    S_DONE = 17'h10000
  } state_e;

  state_e state_q, state_d;

  logic [DT_WIDTH-1:0]  dt_q, dt_d;
  logic [DUR_WIDTH-1:0] dur_q, dur_d;
  pos_t cur_x_q, cur_x_d, cur_y_q, cur_y_d, goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [FRAC_BITS:0] dirx_q, dirx_d, diry_q, diry_d;
  logic dirx_neg_q, dirx_neg_d, diry_neg_q, diry_neg_d;
  logic [EL_WIDTH-1:0]  elapsed_q, elapsed_d;
  logic [DUR_WIDTH-1:0] total_q, total_d;
  logic [30:0] peak_q, peak_d;
  logic        active_q, active_d;
  logic [30:0] axs_q, axs_d, ays_q, ays_d;
  logic        negx_q, negx_d, negy_q, negy_d;
  logic [1:0]  shift_q, shift_d;
  logic [31:0] ds_q, ds_d;
  logic [63:0] tmp_q, tmp_d;
  logic [30:0] sp_q, sp_d;

  // shared serial engines
  logic [63:0] mul_p_q, mul_p_d, mul_a_q, mul_a_d;
  logic [31:0] mul_b_q, mul_b_d;
  logic [39:0] div_r_q, div_r_d;
  logic [63:0] div_n_q, div_n_d, div_qt_q, div_qt_d;
  logic [37:0] div_dv_q, div_dv_d;
  logic [6:0]  div_cnt_q, div_cnt_d;
  logic [63:0] sq_n_q, sq_n_d, sq_r_q, sq_r_d, sq_b_q, sq_b_d;

  logic out_valid_q, out_valid_d, out_m_q, out_m_d;
  pos_t out_x_q, out_x_d, out_y_q, out_y_d;

  logic accept;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid     = out_valid_q;
  assign out_o.pos_x     = out_x_q;
  assign out_o.pos_y     = out_y_q;
  assign out_o.in_motion = out_m_q;

  function automatic pos_t sat_add(pos_t a, logic [30:0] m, logic neg);
    logic signed [POS_WIDTH:0] s;
    logic signed [POS_WIDTH:0] e;
    e = $signed({2'b00, m});
    s = {a[POS_WIDTH-1], a} + (neg ? -e : e);
    if (s[POS_WIDTH] != s[POS_WIDTH-1]) begin
      return s[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}} : {1'b0, {(POS_WIDTH-1){1'b1}}};
    end
    return s[POS_WIDTH-1:0];
  endfunction

  logic signed [POS_WIDTH:0] dx, dy;
  logic [POS_WIDTH:0]        ax, ay;
  logic [1:0]                sh;
  logic [EL_WIDTH:0]         el_sum;
  logic [EL_WIDTH-1:0]       el_next;
  logic [EL_WIDTH-1:0]       e2;
  logic [DUR_WIDTH-1:0]      nm;
  logic [39:0]               rs;
  logic                      qb;
  logic [63:0]               sq_t;
  logic [47:0]               rem;
  logic [31:0]               ds_w;
  logic [30:0]               lim_s;

  always_comb begin
    dx = {in_i.target_x[POS_WIDTH-1], in_i.target_x} - {cur_x_q[POS_WIDTH-1], cur_x_q};
    dy = {in_i.target_y[POS_WIDTH-1], in_i.target_y} - {cur_y_q[POS_WIDTH-1], cur_y_q};
    ax = dx[POS_WIDTH] ? (POS_WIDTH+1)'(-dx) : dx;
    ay = dy[POS_WIDTH] ? (POS_WIDTH+1)'(-dy) : dy;
    if (ax[32] || ay[32]) begin
      sh = 2'd2;
    end else if (ax[31] || ay[31]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    el_sum  = {1'b0, elapsed_q} + (EL_WIDTH+1)'(dt_q);
    el_next = el_sum[EL_WIDTH] ? '1 : el_sum[EL_WIDTH-1:0];
    e2      = {elapsed_q[EL_WIDTH-2:0], 1'b0};
    nm      = (e2 >= EL_WIDTH'(total_q)) ? DUR_WIDTH'(e2 - EL_WIDTH'(total_q))
                                         : DUR_WIDTH'(EL_WIDTH'(total_q) - e2);
    rem     = tmp_q[47:0] - mul_p_q[47:0];
    ds_w    = (sq_r_q[31:0] == 32'd0) ? 32'd1 : sq_r_q[31:0];
    lim_s   = 31'h7FFF_FFFF >> shift_q;

    state_d = state_q;
    dt_d = dt_q; dur_d = dur_q;
    cur_x_d = cur_x_q; cur_y_d = cur_y_q; goal_x_d = goal_x_q; goal_y_d = goal_y_q;
    dirx_d = dirx_q; diry_d = diry_q; dirx_neg_d = dirx_neg_q; diry_neg_d = diry_neg_q;
    elapsed_d = elapsed_q; total_d = total_q; peak_d = peak_q; active_d = active_q;
    axs_d = axs_q; ays_d = ays_q; negx_d = negx_q; negy_d = negy_q;
    shift_d = shift_q; ds_d = ds_q; tmp_d = tmp_q; sp_d = sp_q;
    out_valid_d = out_valid_q; out_x_d = out_x_q; out_y_d = out_y_q; out_m_d = out_m_q;

    // multiplier: one multiplier bit a cycle
    mul_p_d = mul_p_q; mul_a_d = mul_a_q; mul_b_d = mul_b_q;
    if (mul_b_q != 32'd0) begin
      if (mul_b_q[0]) mul_p_d = mul_p_q + mul_a_q;
      mul_a_d = mul_a_q << 1;
      mul_b_d = mul_b_q >> 1;
    end

    // restoring divider: one quotient bit a cycle
    div_r_d = div_r_q; div_n_d = div_n_q; div_qt_d = div_qt_q;
    div_dv_d = div_dv_q; div_cnt_d = div_cnt_q;
    rs = {div_r_q[38:0], div_n_q[63]};
    qb = (rs >= {2'b00, div_dv_q});
    if (div_cnt_q != 7'd0) begin
      div_r_d   = qb ? rs - {2'b00, div_dv_q} : rs;
      div_n_d   = div_n_q << 1;
      div_qt_d  = {div_qt_q[62:0], qb};
      div_cnt_d = div_cnt_q - 7'd1;
    end

    // square root: one result bit a cycle
    sq_n_d = sq_n_q; sq_r_d = sq_r_q; sq_b_d = sq_b_q;
    sq_t = sq_r_q + sq_b_q;
    if (sq_b_q != 64'd0) begin
      if (sq_n_q >= sq_t) begin
        sq_n_d = sq_n_q - sq_t;
        sq_r_d = (sq_r_q >> 1) + sq_b_q;
      end else begin
        sq_r_d = sq_r_q >> 1;
      end
      sq_b_d = sq_b_q >> 2;
    end

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dt_d    = in_i.time_step;
          dur_d   = in_i.duration;
          state_d = S_DONE;
          if (in_i.op == OP_TICK) begin
            if (active_q) begin
              if (elapsed_q >= EL_WIDTH'(total_q)) begin
                active_d  = 1'b0;
                cur_x_d   = goal_x_q;
                cur_y_d   = goal_y_q;
                elapsed_d = el_next;
              end else begin
                mul_p_d = '0; mul_a_d = 64'(total_q); mul_b_d = 32'(total_q);
                state_d = S_TT;
              end
            end
          end else if (in_i.op == OP_MOVE) begin
            if (in_i.duration == '0) begin
              cur_x_d  = in_i.target_x;
              cur_y_d  = in_i.target_y;
              active_d = 1'b0;
            end else begin
              goal_x_d = in_i.target_x;
              goal_y_d = in_i.target_y;
              if (dx != '0 || dy != '0) begin
                shift_d = sh;
                axs_d   = 31'(ax >> sh);
                ays_d   = 31'(ay >> sh);
                negx_d  = dx[POS_WIDTH];
                negy_d  = dy[POS_WIDTH];
                mul_p_d = '0;
                mul_a_d = 64'(31'(ax >> sh));
                mul_b_d = 32'(31'(ax >> sh));
                state_d = S_AXX;
              end
            end
          end else if (in_i.op == OP_SET) begin
            cur_x_d = in_i.target_x;
            cur_y_d = in_i.target_y;
          end
        end
      end
      S_TT: begin
        if (mul_b_q == 32'd0) begin
          tmp_d   = mul_p_q;
          mul_p_d = '0; mul_a_d = 64'(nm); mul_b_d = 32'(nm);
          state_d = S_NN;
        end
      end
      S_NN: begin
        if (mul_b_q == 32'd0) begin
          sq_n_d  = 64'(rem) << 14;
          sq_r_d  = '0;
          sq_b_d  = 64'h4000_0000_0000_0000;
          state_d = S_TSQ;
        end
      end
      S_TSQ: begin
        if (sq_b_q == 64'd0) begin
          div_r_d   = '0;
          div_n_d   = {sq_r_q[30:0], 9'd0, 24'd0};
          div_qt_d  = '0;
          div_dv_d  = 38'(total_q);
          div_cnt_d = 7'd40;
          state_d   = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_cnt_q == 7'd0) begin
          mul_p_d = '0;
          mul_a_d = (div_qt_q > 64'h1_0000) ? 64'h1_0000 : div_qt_q;
          mul_b_d = 32'(dt_q);
          state_d = S_VDT;
        end
      end
      S_VDT: begin
        if (mul_b_q == 32'd0) begin
          mul_p_d = '0;
          mul_a_d = 64'(peak_q);
          mul_b_d = 32'(mul_p_q[FRAC_BITS +: 17]);
          state_d = S_PW;
        end
      end
      S_PW: begin
        if (mul_b_q == 32'd0) begin
          sp_d    = mul_p_q[FRAC_BITS +: 31];
          mul_p_d = '0;
          mul_a_d = 64'(mul_p_q[FRAC_BITS +: 31]);
          mul_b_d = 32'(dirx_q);
          state_d = S_SX;
        end
      end
      S_SX: begin
        if (mul_b_q == 32'd0) begin
          cur_x_d = sat_add(cur_x_q, mul_p_q[FRAC_BITS +: 31], dirx_neg_q);
          mul_p_d = '0;
          mul_a_d = 64'(sp_q);
          mul_b_d = 32'(diry_q);
          state_d = S_SY;
        end
      end
      S_SY: begin
        if (mul_b_q == 32'd0) begin
          cur_y_d   = sat_add(cur_y_q, mul_p_q[FRAC_BITS +: 31], diry_neg_q);
          elapsed_d = el_next;
          state_d   = S_DONE;
        end
      end
      S_AXX: begin
        if (mul_b_q == 32'd0) begin
          tmp_d   = mul_p_q;
          mul_p_d = '0; mul_a_d = 64'(ays_q); mul_b_d = 32'(ays_q);
          state_d = S_AYY;
        end
      end
      S_AYY: begin
        if (mul_b_q == 32'd0) begin
          sq_n_d  = tmp_q + mul_p_q;
          sq_r_d  = '0;
          sq_b_d  = 64'h4000_0000_0000_0000;
          state_d = S_MSQ;
        end
      end
      S_MSQ: begin
        if (sq_b_q == 64'd0) begin
          ds_d      = ds_w;
          div_r_d   = '0;
          div_n_d   = {48'({axs_q, 16'd0}) + 48'(ds_w >> 1), 16'd0};
          div_qt_d  = '0;
          div_dv_d  = 38'(ds_w);
          div_cnt_d = 7'd48;
          state_d   = S_DX;
        end
      end
      S_DX: begin
        if (div_cnt_q == 7'd0) begin
          dirx_d     = div_qt_q[FRAC_BITS:0];
          dirx_neg_d = negx_q;
          div_r_d    = '0;
          div_n_d    = {48'({ays_q, 16'd0}) + 48'(ds_q >> 1), 16'd0};
          div_qt_d   = '0;
          div_dv_d   = 38'(ds_q);
          div_cnt_d  = 7'd48;
          state_d    = S_DY;
        end
      end
      S_DY: begin
        if (div_cnt_q == 7'd0) begin
          diry_d     = div_qt_q[FRAC_BITS:0];
          diry_neg_d = negy_q;
          mul_p_d    = '0;
          mul_a_d    = 64'(ds_q);
          mul_b_d    = 32'(FOUR_OVER_PI_Q30);
          state_d    = S_DK;
        end
      end
      S_DK: begin
        if (mul_b_q == 32'd0) begin
          div_r_d   = '0;
          div_n_d   = mul_p_q + (64'(dur_q) << 13);
          div_qt_d  = '0;
          div_dv_d  = {dur_q, 14'd0};
          div_cnt_d = 7'd64;
          state_d   = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_cnt_q == 7'd0) begin
          peak_d    = (div_qt_q > 64'(lim_s)) ? 31'h7FFF_FFFF
                                              : 31'(div_qt_q[30:0] << shift_q);
          elapsed_d = '0;
          total_d   = dur_q;
          active_d  = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_x_d     = cur_x_q;
          out_y_d     = cur_y_q;
          out_m_d     = active_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      dirx_q      <= '0;
      diry_q      <= '0;
      dirx_neg_q  <= 1'b0;
      diry_neg_q  <= 1'b0;
      elapsed_q   <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mul_b_q     <= '0;
      div_cnt_q   <= '0;
      sq_b_q      <= '0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      dirx_q      <= dirx_d;
      diry_q      <= diry_d;
      dirx_neg_q  <= dirx_neg_d;
      diry_neg_q  <= diry_neg_d;
      elapsed_q   <= elapsed_d;
      total_q     <= total_d;
      peak_q      <= peak_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      mul_b_q     <= mul_b_d;
      div_cnt_q   <= div_cnt_d;
      sq_b_q      <= sq_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q     <= dt_d;
    dur_q    <= dur_d;
    axs_q    <= axs_d;
    ays_q    <= ays_d;
    negx_q   <= negx_d;
    negy_q   <= negy_d;
    shift_q  <= shift_d;
    ds_q     <= ds_d;
    tmp_q    <= tmp_d;
    sp_q     <= sp_d;
    mul_p_q  <= mul_p_d;
    mul_a_q  <= mul_a_d;
    div_r_q  <= div_r_d;
    div_n_q  <= div_n_d;
    div_qt_q <= div_qt_d;
    div_dv_q <= div_dv_d;
    sq_n_q   <= sq_n_d;
    sq_r_q   <= sq_r_d;
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    out_m_q  <= out_m_d;
  end

endmodule

// File: tb/tb_smooth_pan_profile_2d.sv
// ----------------------------------------------------------------------------
// tb_smooth_pan_profile_2d
// Drives ticks, moves, set-position and unknown-op items into the pan profile generator,
// predicts every result in the bench and checks the output in order.
// ----------------------------------------------------------------------------
module tb_smooth_pan_profile_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import spp_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] time_step;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [23:0] duration;
  } pan_cmd_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        in_motion;
  } pan_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  spp_in_if  in_ch ();
  spp_out_if out_ch ();

  smooth_pan_profile_2d dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  pan_cmd_t pending_cmds[$];
  pan_pos_t expected_pos[$];
  int       error_count = 0;
  longint   cycle_count = 0;
  bit       calm_phase = 1'b0;
  int       hold_cycles = 0;
  bit       hold_done = 1'b0;

  // Predictor state
  longint signed  p_cur_x, p_cur_y, p_goal_x, p_goal_y, p_dir_x, p_dir_y;
  longint unsigned p_elapsed, p_total, p_peak;
  bit p_active;

  localparam longint signed PMAX = 64'sd2147483647;

  function automatic longint signed sat32(longint signed v);
    if (v > PMAX) return PMAX;
    if (v < -PMAX - 1) return -PMAX - 1;
    return v;
  endfunction

  function automatic longint unsigned sqrt64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint signed v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed axis_step(longint unsigned sp, longint signed dir);
    longint unsigned m, d;
    m = absval(dir);
    d = (sp >> 16) * m + (((sp & 64'hFFFF) * m) >> 16);
    return dir < 0 ? -longint'(d) : longint'(d);
  endfunction

  function automatic pan_pos_t predict_pan(pan_cmd_t c);
    longint signed tx, ty, dx, dy, num;
    longint unsigned ax, ay, axs, ays, ds, q, den, rem, r, v, w, sp;
    int s;
    pan_pos_t res;
    tx = longint'($signed(c.target_x));
    ty = longint'($signed(c.target_y));
    if (c.op == OP_TICK) begin
      if (p_active) begin
        if (p_elapsed >= p_total) begin
          p_active = 1'b0;
          p_cur_x = p_goal_x;
          p_cur_y = p_goal_y;
        end else begin
          num = longint'(2 * p_elapsed) - longint'(p_total);
          rem = p_total * p_total - absval(num) * absval(num);
          r = sqrt64(rem << 14);
          v = (r << 9) / p_total;
          if (v > 64'h10000) v = 64'h10000;
          w = (v * c.time_step) >> 16;
          sp = (p_peak * w) >> 16;
          p_cur_x = sat32(p_cur_x + axis_step(sp, p_dir_x));
          p_cur_y = sat32(p_cur_y + axis_step(sp, p_dir_y));
        end
        p_elapsed += c.time_step;
        if (p_elapsed > 64'h1FFFFFF) p_elapsed = 64'h1FFFFFF;
      end
    end else if (c.op == OP_MOVE) begin
      if (c.duration == 0) begin
        p_cur_x = tx;
        p_cur_y = ty;
        p_active = 1'b0;
      end else begin
        p_goal_x = tx;
        p_goal_y = ty;
        dx = tx - p_cur_x;
        dy = ty - p_cur_y;
        if (dx != 0 || dy != 0) begin
          ax = absval(dx);
          ay = absval(dy);
          s = 0;
          while ((ax >> s) >= (64'd1 << 31) || (ay >> s) >= (64'd1 << 31)) s++;
          axs = ax >> s;
          ays = ay >> s;
          ds = sqrt64(axs * axs + ays * ays);
          if (ds == 0) ds = 1;
          p_dir_x = longint'(((axs << 16) + ds / 2) / ds);
          p_dir_y = longint'(((ays << 16) + ds / 2) / ds);
          if (dx < 0) p_dir_x = -p_dir_x;
          if (dy < 0) p_dir_y = -p_dir_y;
          den = longint'(c.duration) << 14;
          q = (ds * longint'(FOUR_OVER_PI_Q30) + den / 2) / den;
          p_peak = (q > (PMAX >> s)) ? PMAX : (q << s);
          if (p_peak > PMAX) p_peak = PMAX;
          p_elapsed = 0;
          p_total = c.duration;
          p_active = 1'b1;
        end
      end
    end else if (c.op == OP_SET) begin
      p_cur_x = tx;
      p_cur_y = ty;
    end
    res.pos_x = p_cur_x[31:0];
    res.pos_y = p_cur_y[31:0];
    res.in_motion = p_active;
    return res;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic pan_cmd_t make_cmd(logic [1:0] op, logic [15:0] dt,
                                        logic [31:0] x, logic [31:0] y,
                                        logic [23:0] dur);
    pan_cmd_t c;
    c.op = op;
    c.time_step = dt;
    c.target_x = x;
    c.target_y = y;
    c.duration = dur;
    return c;
  endfunction

  // Append an item to the stimulus queue
  task automatic add_cmd(pan_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.op        <= OP_TICK;
      in_ch.time_step <= '0;
      in_ch.target_x  <= '0;
      in_ch.target_y  <= '0;
      in_ch.duration  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) void'(pending_cmds.pop_front());
      if (pending_cmds.size() > (in_ch.valid ? 0 : 0) &&
          (calm_phase || $urandom_range(0, 99) >= 28)) begin
        in_ch.valid     <= 1'b1;
        in_ch.op        <= pending_cmds[0].op;
        in_ch.time_step <= pending_cmds[0].time_step;
        in_ch.target_x  <= pending_cmds[0].target_x;
        in_ch.target_y  <= pending_cmds[0].target_y;
        in_ch.duration  <= pending_cmds[0].duration;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance
  always @(posedge clk_i) begin
    pan_pos_t nxt;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      nxt = predict_pan(make_cmd(in_ch.op, in_ch.time_step,
          in_ch.target_x, in_ch.target_y, in_ch.duration));
      expected_pos = {expected_pos, nxt};
    end
  end

  // Receiver ready, with one long hold-off once the run is under way
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (!hold_done && cycle_count > 20000) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 3000) hold_done <= 1'b1;
    end else begin
      out_ch.ready <= calm_phase || $urandom_range(0, 99) >= 28;
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    pan_pos_t got, exp_p;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.pos_x = out_ch.pos_x;
      got.pos_y = out_ch.pos_y;
      got.in_motion = out_ch.in_motion;
      if (expected_pos.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        exp_p = expected_pos.pop_front();
        if (got.pos_x !== exp_p.pos_x)
          $display("%0t: pos_x expected %h actual %h", $time, exp_p.pos_x, got.pos_x);
        if (got.pos_y !== exp_p.pos_y)
          $display("%0t: pos_y expected %h actual %h", $time, exp_p.pos_y, got.pos_y);
        if (got.in_motion !== exp_p.in_motion)
          $display("%0t: in_motion expected %b actual %b", $time, exp_p.in_motion,
                   got.in_motion);
        if (got !== exp_p) error_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb_smooth_pan_profile_2d: done, errors");
      $finish;
    end
  end

  initial begin
    int n, k, dur;
    logic [31:0] x, y;
    p_cur_x = 0; p_cur_y = 0; p_goal_x = 0; p_goal_y = 0; p_dir_x = 0; p_dir_y = 0;
    p_elapsed = 0; p_total = 0; p_peak = 0; p_active = 1'b0;

    // Directed: idle tick, unknown op, jump, set, move to self, extremes
    add_cmd(make_cmd(OP_TICK, 16'hFFFF, '0, '0, '0));
    add_cmd(make_cmd(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF));
    add_cmd(make_cmd(OP_MOVE, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0));
    add_cmd(make_cmd(OP_MOVE, '0, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1));
    for (k = 0; k < 4; k++)
      add_cmd(make_cmd(OP_TICK, 16'hFFFF, '0, '0, '0));
    add_cmd(make_cmd(OP_SET, '0, 32'h0001_0000, 32'hFFFF_0000, '0));
    add_cmd(make_cmd(OP_MOVE, '0, 32'h0001_0000, 32'hFFFF_0000, 24'd100));
    add_cmd(make_cmd(OP_MOVE, '0, 32'h0064_0000, 32'h0032_0000, 24'h02_0000));
    for (k = 0; k < 6; k++)
      add_cmd(make_cmd(OP_TICK, 16'h1000, '0, '0, '0));
    add_cmd(make_cmd(OP_SET, '0, 32'h0000_0000, 32'h0000_0000, '0));
    add_cmd(make_cmd(OP_MOVE, '0, 32'h0000_0000, 32'h0000_0000, 24'd5));
    for (k = 0; k < 3; k++)
      add_cmd(make_cmd(OP_TICK, 16'h8000, '0, '0, '0));
    add_cmd(make_cmd(OP_MOVE, '0, 32'h1234_5678, 32'h8765_4321, 24'hFFFFFF));
    add_cmd(make_cmd(OP_TICK, 16'h0000, '0, '0, '0));

    // Random: mostly moves followed by runs of ticks
    n = 0;
    while (n < 450) begin
      k = $urandom_range(0, 99);
      x = rand_pos();
      y = rand_pos();
      if (k < 60) begin
        dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 24'h04_0000);
        if ($urandom_range(0, 15) == 0) dur = 0;
        add_cmd(make_cmd(OP_MOVE, 16'($urandom), x, y, 24'(dur)));
        n++;
        repeat ($urandom_range(1, 12)) begin
          add_cmd(make_cmd(OP_TICK,
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16'h2000)),
              $urandom, $urandom, 24'($urandom)));
          n++;
        end
      end else if (k < 80) begin
        add_cmd(make_cmd(OP_SET, 16'($urandom), x, y, 24'($urandom)));
        n++;
      end else begin
        add_cmd(make_cmd(2'($urandom_range(0, 3)), 16'($urandom), x, y,
                         24'($urandom)));
        n++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run without idling for a stretch midway
    wait (pending_cmds.size() < 200);
    calm_phase = 1'b1;
    wait (pending_cmds.size() < 120);
    calm_phase = 1'b0;

    wait (pending_cmds.size() == 0 && !in_ch.valid);
    wait (expected_pos.size() == 0);
    repeat (600) @(posedge clk_i);
    if (error_count == 0 && expected_pos.size() == 0)
      $display("tb_smooth_pan_profile_2d: done, clean");
    else
      $display("tb_smooth_pan_profile_2d: done, errors");
    $finish;
  end

endmodule
